@@ rtl/day_length_from_month_latitude_top_macros.svh @@
// Assertion macros for the day length block.
`ifndef DAY_LENGTH_FROM_MONTH_LATITUDE_TOP_MACROS_SVH
`define DAY_LENGTH_FROM_MONTH_LATITUDE_TOP_MACROS_SVH
`ifndef SYNTH
`define DL_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define DL_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define DL_ASSERT_IMP(label, clk, rst_n, a, c)
`define DL_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/dlml_pkg.sv @@
package dlml_pkg;
    localparam int Steps = 16;
    localparam int LatLimit = 9000;
    localparam int Depth = 53;

    // Rotation stage values: x and y stay within about 27000 in magnitude.
    typedef logic signed [17:0] rot_t;
    typedef logic signed [18:0] ang_t;
    typedef logic signed [37:0] sq_t;
    typedef logic signed [22:0] vec_t;

    function automatic logic [14:0] atan_step(input logic [4:0] i);
        logic [14:0] v;
        case (i)
            5'd0: v = 15'd16384;
            5'd1: v = 15'd9672;
            5'd2: v = 15'd5110;
            5'd3: v = 15'd2594;
            5'd4: v = 15'd1302;
            5'd5: v = 15'd652;
            5'd6: v = 15'd326;
            5'd7: v = 15'd163;
            5'd8: v = 15'd81;
            5'd9: v = 15'd41;
            5'd10: v = 15'd20;
            5'd11: v = 15'd10;
            5'd12: v = 15'd5;
            5'd13: v = 15'd3;
            default: v = 15'd1;
        endcase
        return v;
    endfunction

    function automatic logic signed [14:0] decl(input logic [3:0] m);
        logic signed [14:0] v;
        case (m)
            4'd0: v = -15'sd6351;
            4'd1: v = -15'sd4600;
            4'd2: v = -15'sd1789;
            4'd3: v = 15'sd1679;
            4'd4: v = 15'sd4600;
            4'd5: v = 15'sd6351;
            4'd6: v = 15'sd6366;
            4'd7: v = 15'sd4640;
            4'd8: v = 15'sd1625;
            4'd9: v = -15'sd1734;
            4'd10: v = -15'sd4720;
            default: v = -15'sd6393;
        endcase
        return v;
    endfunction

    function automatic logic signed [14:0] tan_decl(input logic [3:0] m);
        logic signed [14:0] v;
        case (m)
            4'd0: v = -15'sd6690;
            4'd1: v = -15'sd4725;
            4'd2: v = -15'sd1796;
            4'd3: v = 15'sd1685;
            4'd4: v = 15'sd4725;
            4'd5: v = 15'sd6690;
            4'd6: v = 15'sd6707;
            4'd7: v = 15'sd4768;
            4'd8: v = 15'sd1630;
            4'd9: v = -15'sd1741;
            4'd10: v = -15'sd4855;
            default: v = -15'sd6739;
        endcase
        return v;
    endfunction
endpackage

@@ rtl/dlml_rotate.sv @@
// Front end: input clamp, angle scaling, then 16 CORDIC rotation stages.
module dlml_rotate
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [3:0]           month_number,
    input  logic signed [14:0]   latitude_centideg,
    output logic                 out_valid,
    output logic [3:0]           midx,
    output dlml_pkg::rot_t       cos_val,
    output dlml_pkg::rot_t       sin_val
);
    logic                 v_reg [0:dlml_pkg::Steps+1];
    logic [3:0]           m_reg [0:dlml_pkg::Steps+1];
    logic                 s_reg [0:dlml_pkg::Steps+1];
    dlml_pkg::rot_t       x_reg [1:dlml_pkg::Steps+1];
    dlml_pkg::rot_t       y_reg [1:dlml_pkg::Steps+1];
    dlml_pkg::ang_t       z_reg [1:dlml_pkg::Steps+1];
    logic [13:0]          mag_reg;
    logic [29:0]          prod_next;
    logic signed [14:0]   lat_c;
    logic [3:0]           m_c;

    always_comb
    begin
        lat_c = latitude_centideg;
        if (latitude_centideg > 15'sd9000)
            lat_c = 15'sd9000;
        if (latitude_centideg < -15'sd9000)
            lat_c = -15'sd9000;
        m_c = month_number;
        if (month_number < 4'd1)
            m_c = 4'd1;
        if (month_number > 4'd12)
            m_c = 4'd12;
        // Divide by 18000 through a reciprocal: floor(p*488671835/2^43) is exact here.
        prod_next = {mag_reg, 16'd0} + 30'd9000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= dlml_pkg::Steps+1; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= dlml_pkg::Steps+1; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= lat_c[14] ? 14'(-lat_c) : 14'(lat_c);
        s_reg[0] <= lat_c[14];
        m_reg[0] <= m_c - 4'd1;
        x_reg[1] <= 18'sd16384;
        y_reg[1] <= '0;
        z_reg[1] <= 19'(({29'd0, prod_next} * 59'd488671835) >> 43);
        s_reg[1] <= s_reg[0];
        m_reg[1] <= m_reg[0];
        for (int k = 1; k <= dlml_pkg::Steps; k++)
        begin
            s_reg[k+1] <= s_reg[k];
            m_reg[k+1] <= m_reg[k];
            if (!z_reg[k][18])
            begin
                x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> (k-1));
                y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> (k-1));
                z_reg[k+1] <= z_reg[k] - 19'(dlml_pkg::atan_step(5'(k-1)));
            end
            else
            begin
                x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> (k-1));
                y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> (k-1));
                z_reg[k+1] <= z_reg[k] + 19'(dlml_pkg::atan_step(5'(k-1)));
            end
        end
    end

    assign out_valid = v_reg[dlml_pkg::Steps+1];
    assign midx      = m_reg[dlml_pkg::Steps+1];
    assign cos_val   = x_reg[dlml_pkg::Steps+1];
    assign sin_val   = s_reg[dlml_pkg::Steps+1] ? -y_reg[dlml_pkg::Steps+1]
                                                 : y_reg[dlml_pkg::Steps+1];
endmodule

@@ rtl/dlml_sqrt.sv @@
// Products, radicand, then a one-bit-per-stage restoring square root.
module dlml_sqrt
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [3:0]       midx,
    input  dlml_pkg::rot_t   cos_val,
    input  dlml_pkg::rot_t   sin_val,
    output logic             out_valid,
    output dlml_pkg::vec_t   root,
    output dlml_pkg::vec_t   q_val
);
    localparam int Bits = 15;
    logic                  v_reg [0:Bits+1];
    dlml_pkg::vec_t        q_reg [0:Bits+1];
    dlml_pkg::rot_t        u_reg;
    dlml_pkg::rot_t        c_reg;
    logic [31:0]           rem_reg [1:Bits+1];
    logic [15:0]           res_reg [1:Bits+1];
    logic signed [32:0]    pu;
    logic signed [32:0]    pq;
    logic signed [36:0]    rad_next;

    always_comb
    begin
        pu = 33'(sin_val) * 33'(dlml_pkg::decl(midx)) + 33'sd8192;
        pq = 33'(sin_val) * 33'(dlml_pkg::tan_decl(midx)) + 33'sd8192;
        rad_next = 37'(c_reg) * 37'(c_reg) - 37'(u_reg) * 37'(u_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= Bits+1; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= Bits+1; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= 18'(pu >>> 14);
        c_reg    <= cos_val;
        q_reg[0] <= -23'(pq >>> 14);
        q_reg[1] <= q_reg[0];
        rem_reg[1] <= rad_next[36] ? 32'd0 : 32'(rad_next);
        res_reg[1] <= '0;
        for (int k = 1; k <= Bits; k++)
        begin
            logic [31:0] trial;
            logic [31:0] bitv;
            bitv  = 32'd1 << (2*(Bits-k));
            q_reg[k+1] <= q_reg[k];
            // Trial subtract of (2*res + 2^n) * 2^n from the remainder.
            trial = ({16'd0, res_reg[k]} << (Bits-k+1)) + bitv;
            if (rem_reg[k] >= trial)
            begin
                rem_reg[k+1] <= rem_reg[k] - trial;
                res_reg[k+1] <= res_reg[k] | 16'(32'd1 << (Bits-k));
            end
            else
            begin
                rem_reg[k+1] <= rem_reg[k];
                res_reg[k+1] <= res_reg[k];
            end
        end
    end

    assign out_valid = v_reg[Bits+1];
    assign root      = dlml_pkg::vec_t'(res_reg[Bits+1]);
    assign q_val     = q_reg[Bits+1];
endmodule

@@ rtl/dlml_vector.sv @@
// CORDIC vectoring over 16 stages, then clamp and hour scaling.
module dlml_vector
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  dlml_pkg::vec_t   root,
    input  dlml_pkg::vec_t   q_val,
    output logic             out_valid,
    output logic [14:0]      day_length
);
    logic               v_reg [1:dlml_pkg::Steps+2];
    dlml_pkg::vec_t     x_reg [1:dlml_pkg::Steps+1];
    dlml_pkg::vec_t     y_reg [1:dlml_pkg::Steps+1];
    dlml_pkg::ang_t     z_reg [1:dlml_pkg::Steps+1];
    logic [14:0]        dl_reg;
    logic [16:0]        zc;
    logic [18:0]        dl_next;

    always_comb
    begin
        if (z_reg[dlml_pkg::Steps+1][18])
            zc = '0;
        else if (z_reg[dlml_pkg::Steps+1] > 19'sd65536)
            zc = 17'd65536;
        else
            zc = 17'(z_reg[dlml_pkg::Steps+1]);
        dl_next = ({2'b0, zc} * 19'd3 + 19'd4) >> 3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= dlml_pkg::Steps+2; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            v_reg[1] <= in_valid;
            for (int k = 2; k <= dlml_pkg::Steps+2; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_val[22])
        begin
            x_reg[1] <= root;
            y_reg[1] <= -q_val;
            z_reg[1] <= 19'sd32768;
        end
        else
        begin
            x_reg[1] <= q_val;
            y_reg[1] <= root;
            z_reg[1] <= '0;
        end
        for (int k = 1; k <= dlml_pkg::Steps; k++)
        begin
            if (y_reg[k] > 23'sd0)
            begin
                x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> (k-1));
                y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> (k-1));
                z_reg[k+1] <= z_reg[k] + 19'(dlml_pkg::atan_step(5'(k-1)));
            end
            else
            begin
                x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> (k-1));
                y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> (k-1));
                z_reg[k+1] <= z_reg[k] - 19'(dlml_pkg::atan_step(5'(k-1)));
            end
        end
        dl_reg <= dl_next[14:0];
    end

    assign out_valid  = v_reg[dlml_pkg::Steps+2];
    assign day_length = dl_reg;
endmodule

@@ rtl/day_length_from_month_latitude_top.sv @@
// Channel  | Ports                                   | Handshake
// input    | month_number, latitude_centideg         | start high, busy low
// result   | day_length                              | done, one cycle
//
// One item enters every cycle; busy is always low.
// The pipeline holds 18 rotation stages, 17 square root stages
// and 18 vectoring stages including the output register.
// Reset clears only the valid bits along the pipeline.
// The receiver cannot stall, so results leave as they arrive.
`include "day_length_from_month_latitude_top_macros.svh"
module day_length_from_month_latitude_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [3:0]          month_number,
    input  logic signed [14:0]  latitude_centideg,
    output logic                done,
    output logic [14:0]         day_length
);
    logic             rv;
    logic [3:0]       midx;
    dlml_pkg::rot_t   cos_val;
    dlml_pkg::rot_t   sin_val;
    logic             sv;
    dlml_pkg::vec_t   root;
    dlml_pkg::vec_t   q_val;

    assign busy = 1'b0;

    dlml_rotate u_rot
    (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .month_number(month_number), .latitude_centideg(latitude_centideg),
        .out_valid(rv), .midx(midx),
        .cos_val(cos_val), .sin_val(sin_val)
    );

    dlml_sqrt u_sqrt
    (
        .clk(clk), .rst_n(rst_n), .in_valid(rv), .midx(midx),
        .cos_val(cos_val), .sin_val(sin_val),
        .out_valid(sv), .root(root), .q_val(q_val)
    );

    dlml_vector u_vec
    (
        .clk(clk), .rst_n(rst_n), .in_valid(sv), .root(root), .q_val(q_val),
        .out_valid(done), .day_length(day_length)
    );

    `DL_ASSERT_IMP(a_range, clk, rst_n, done, day_length <= 15'd24576)
    `DL_ASSERT_IMP(a_root_pos, clk, rst_n, sv, !root[22])
    `DL_ASSERT_IMP(a_no_busy, clk, rst_n, 1'b1, !busy)
endmodule
